[src/sine_cosine_from_centidegrees_top_assert.svh]
// Assertion macros for the sine/cosine block checkers.
// No dependencies; included by the checker file only.
`ifndef SINE_COSINE_FROM_CENTIDEGREES_TOP_ASSERT_SVH
`define SINE_COSINE_FROM_CENTIDEGREES_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SCCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sccd assertion failed");

// Next-cycle implication, checked out of reset.
`define SCCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sccd assertion failed");

`endif

[src/sccd_pkg.sv]
// Shared constants, types and ROM tables for the sine/cosine block.
// No dependencies; ROM contents are built at elaboration.
package sccd_pkg;

  localparam int FracBits  = 16;
  localparam int AngleW    = 16;
  localparam int OutW      = FracBits + 2;
  localparam int RomW      = FracBits + 1;
  localparam int DegW      = 9;   // holds up to 450
  localparam int FracW     = 7;   // holds up to 99
  localparam int DegQW     = 10;  // whole degrees of a 16-bit angle
  localparam int AccW      = 2 * RomW + 1;

  // floor(angle / 100) = (angle * DegDivMul) >> DegDivShift for 16-bit angles
  localparam logic [16:0] DegDivMul   = 17'd83887;
  localparam int          DegDivShift = 23;

  localparam logic [63:0] PiQ62     = 64'hC90FDAA22168C235;
  localparam logic [63:0] Q62One    = 64'h4000000000000000;
  localparam logic [63:0] DegStep   = PiQ62 / 180;
  localparam logic [63:0] FracStep  = PiQ62 / 18000;

  typedef logic [RomW-1:0] deg_rom_t  [0:90];
  typedef logic [RomW-1:0] frac_rom_t [0:50];

  // one folded lookup: four ROM words plus sign handling
  typedef struct packed {
    logic            neg;
    logic            sub;
    logic [RomW-1:0] cos_frac;
    logic [RomW-1:0] sin_deg;
    logic [RomW-1:0] sin_frac;
    logic [RomW-1:0] sin_deg_c;
  } fold_t;

  // pipeline load strobes into a sine path
  typedef struct packed {
    logic ld_rom;
    logic ld_out;
  } stage_en_t;

  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // restoring long division, used only while the ROMs are built
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] q62_series(input logic [63:0] x, input logic odd);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] n;
    x2   = q62_mul(x, x);
    term = odd ? x : Q62One;
    sum  = term;
    n    = odd ? 64'd1 : 64'd0;
    for (int k = 0; k < 14; k++) begin
      term = udiv64(q62_mul(term, x2), (n + 64'd1) * (n + 64'd2));
      n    = n + 64'd2;
      if ((k % 2) == 1) sum = sum + term;
      else sum = sum - term;
    end
    return sum;
  endfunction

  function automatic logic [RomW-1:0] to_rom(input logic [63:0] v);
    logic [63:0] t;
    t = v + (64'd1 << (61 - FracBits));
    return t[62-FracBits +: RomW];
  endfunction

  function automatic deg_rom_t build_sin_deg();
    deg_rom_t r;
    for (int i = 0; i <= 90; i++) begin
      r[i] = to_rom(q62_series(DegStep * 64'(i), 1'b1));
    end
    return r;
  endfunction

  function automatic frac_rom_t build_frac(input logic odd);
    frac_rom_t r;
    for (int i = 0; i <= 50; i++) begin
      r[i] = to_rom(q62_series(FracStep * 64'(i), odd));
    end
    return r;
  endfunction

  localparam deg_rom_t  SinDegRom  = build_sin_deg();
  localparam frac_rom_t SinFracRom = build_frac(1'b1);
  localparam frac_rom_t CosFracRom = build_frac(1'b0);

endpackage

[src/sccd_sine_path.sv]
// Sine of (deg + frac/100) degrees: quadrant fold, ROM lookup, angle-sum MAC.
// Depends on sccd_pkg (ROM tables, fold_t, stage_en_t).
module sccd_sine_path (
  input  logic                      clk_i,
  input  sccd_pkg::stage_en_t       en_i,
  input  logic [sccd_pkg::DegW-1:0] deg_i,
  input  logic [sccd_pkg::FracW-1:0] frac_i,
  output logic signed [sccd_pkg::OutW-1:0] value_o
);
  import sccd_pkg::*;

  fold_t fold_d, fold_q;
  logic signed [OutW-1:0] value_d, value_q;

  // fold onto 0..90 degrees and 0..50 hundredths
  always_comb begin
    logic [DegW-1:0]  d;
    logic [FracW-1:0] f;
    logic [6:0]       di;
    logic [6:0]       dc;
    logic [5:0]       fi;
    d = deg_i;
    f = frac_i;
    fold_d.neg = 1'b0;
    fold_d.sub = 1'b0;
    if (d >= DegW'(360)) d = d - DegW'(360);
    if (f > FracW'(99)) f = FracW'(99);
    if (d >= DegW'(180)) begin
      fold_d.neg = 1'b1;
      d = d - DegW'(180);
    end
    if (d >= DegW'(90)) begin
      d = DegW'(180) - d;
      if (f != '0) begin
        d = d - DegW'(1);
        f = FracW'(100) - f;
      end
    end
    if (f > FracW'(50)) begin
      fold_d.sub = 1'b1;
      f = FracW'(100) - f;
      d = d + DegW'(1);
    end
    if (d > DegW'(90)) d = DegW'(90);
    if (f > FracW'(50)) f = FracW'(50);
    di = d[6:0];
    dc = 7'd90 - di;
    fi = f[5:0];
    fold_d.cos_frac  = CosFracRom[fi];
    fold_d.sin_deg   = SinDegRom[di];
    fold_d.sin_frac  = SinFracRom[fi];
    fold_d.sin_deg_c = SinDegRom[dc];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld_rom) fold_q <= fold_d;
  end

  // cos(f)*sin(d) +/- sin(f)*cos(d), round half away from zero, sign last
  always_comb begin
    logic signed [AccW-1:0] p1;
    logic signed [AccW-1:0] p2;
    logic signed [AccW-1:0] acc;
    logic        [AccW-1:0] mag_acc;
    logic        [AccW-1:0] rnd;
    logic signed [OutW-1:0] mag;
    p1 = $signed({1'b0, {RomW{1'b0}}, fold_q.cos_frac} * {{(RomW+1){1'b0}}, fold_q.sin_deg});
    p2 = $signed({1'b0, {RomW{1'b0}}, fold_q.sin_frac} * {{(RomW+1){1'b0}}, fold_q.sin_deg_c});
    acc = fold_q.sub ? (p1 - p2) : (p1 + p2);
    mag_acc = acc[AccW-1] ? AccW'(-acc) : AccW'(acc);
    rnd = (mag_acc + (AccW'(1) << (FracBits - 1))) >> FracBits;
    mag = $signed(rnd[OutW-1:0]);
    value_d = (acc[AccW-1] ^ fold_q.neg) ? -mag : mag;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld_out) value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

[src/sine_cosine_from_centidegrees_top.sv]
// Sine and cosine of an angle in hundredths of a degree, signed Q1.16 out.
// Pipeline: five register stages (input reg, degree split, path args, ROM
// words, result); each result waits in the last stage until it is taken.
// Throughput: one request per cycle; every stage holds its own valid bit, so
// a waiting result only stalls the stages behind it once they fill up.
// Reset: rst_ni (async, active low) clears all stage valid bits; data
// registers are not reset. ROMs are constant tables.
module sine_cosine_from_centidegrees_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] angle_centideg
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [17:0] sine_value, [35:18] cosine_value, [39:36] zero
);
  import sccd_pkg::*;

  // stage valids: 1 input reg, 2 degree split, 3 path args, 4 ROM words, 5 result
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [AngleW-1:0] angle1_q, angle2_q;
  logic [DegQW-1:0]  deg2_q;
  logic [DegW-1:0]   sdeg3_q, cdeg3_q;
  logic [FracW-1:0]  sfrac3_q, cfrac3_q;

  logic [AngleW+16:0] div_prod;
  logic [DegQW-1:0]   deg_d;
  logic [AngleW-1:0]  frac_wide;
  logic [FracW-1:0]   frac_d;
  logic [DegW-1:0]    dmod_d;
  logic [DegW-1:0]    cdeg_d;
  logic [FracW-1:0]   cfrac_d;

  stage_en_t en;
  logic signed [OutW-1:0] sine_val, cosine_val;

  // backpressure: a stage moves when it is empty or the next one moves
  assign rdy5 = !v5_q || m_axis_tready;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // whole degrees by reciprocal multiply (exact for all 16-bit angles)
  assign div_prod = {{(AngleW+1){1'b0}}, angle1_q} * {16'd0, DegDivMul};
  assign deg_d    = div_prod[DegDivShift +: DegQW];

  // hundredths, degrees mod 360, and the reflected cosine argument
  assign frac_wide = angle2_q - AngleW'(deg2_q) * AngleW'(100);
  assign frac_d    = frac_wide[FracW-1:0];
  assign dmod_d    = (deg2_q >= DegQW'(360)) ? DegW'(deg2_q - DegQW'(360)) : deg2_q[DegW-1:0];

  always_comb begin
    if (frac_d == '0) begin
      cdeg_d  = DegW'(450) - dmod_d;
      cfrac_d = '0;
    end else begin
      cdeg_d  = DegW'(449) - dmod_d;
      cfrac_d = FracW'(100) - frac_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) angle1_q <= s_axis_tdata;
    if (rdy2 && v1_q) begin
      angle2_q <= angle1_q;
      deg2_q   <= deg_d;
    end
    if (rdy3 && v2_q) begin
      sdeg3_q  <= dmod_d;
      sfrac3_q <= frac_d;
      cdeg3_q  <= cdeg_d;
      cfrac3_q <= cfrac_d;
    end
  end

  assign en.ld_rom = rdy4 && v3_q;
  assign en.ld_out = rdy5 && v4_q;

  sccd_sine_path u_sine (
    .clk_i   (clk_i),
    .en_i    (en),
    .deg_i   (sdeg3_q),
    .frac_i  (sfrac3_q),
    .value_o (sine_val)
  );

  // cosine runs the same path on the reflected argument
  sccd_sine_path u_cosine (
    .clk_i   (clk_i),
    .en_i    (en),
    .deg_i   (cdeg3_q),
    .frac_i  (cfrac3_q),
    .value_o (cosine_val)
  );

  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata  = {4'b0000, cosine_val, sine_val};

endmodule

[src/sccd_port_checker.sv]
// Port-level checker for the sine/cosine block, bound to the top level.
// Depends on sine_cosine_from_centidegrees_top_assert.svh.
`include "sine_cosine_from_centidegrees_top_assert.svh"

module sccd_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  logic stalled;
  logic sin_ok, cos_ok, not_both_zero;

  assign stalled = m_axis_tvalid && !m_axis_tready;

  // within -1.0 .. +1.0 in Q1.16
  assign sin_ok = (m_axis_tdata[17] ? m_axis_tdata[16] :
                   (!m_axis_tdata[16] || (m_axis_tdata[15:0] == 16'd0)));
  assign cos_ok = (m_axis_tdata[35] ? m_axis_tdata[34] :
                   (!m_axis_tdata[34] || (m_axis_tdata[33:18] == 16'd0)));
  assign not_both_zero = (m_axis_tdata[17:0] != 18'd0) || (m_axis_tdata[35:18] != 18'd0);

  `SCCD_ASSERT_NEXT(a_valid_held, clk_i, rst_ni, stalled, m_axis_tvalid)
  `SCCD_ASSERT_NEXT(a_data_held, clk_i, rst_ni, stalled, $stable(m_axis_tdata))
  `SCCD_ASSERT_IMPLY(a_range, clk_i, rst_ni, m_axis_tvalid, sin_ok && cos_ok)
  `SCCD_ASSERT_IMPLY(a_nonzero, clk_i, rst_ni, m_axis_tvalid, not_both_zero)
  `SCCD_ASSERT_IMPLY(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[39:36] == 4'd0)

endmodule

bind sine_cosine_from_centidegrees_top sccd_port_checker u_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[sim/sine_cosine_from_centidegrees_top_tb.sv]
// Self-checking testbench for sine_cosine_from_centidegrees_top: angles in
// centidegrees go in, Q1.16 sine/cosine pairs come out and are checked against
// an in-bench predictor with its own ROM tables. Depends only on the RTL.
`timescale 1ns / 1ps

module sine_cosine_from_centidegrees_top_tb;

  localparam int FRAC       = 16;
  localparam int LATENCY    = 5;
  localparam int CYCLE_CAP  = 400000;
  localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
  localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

  typedef struct {
    logic [15:0]        angle;
    logic signed [17:0] sine_q;
    logic signed [17:0] cosine_q;
  } trig_pair_t;

  typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] angle_centideg
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [17:0] sine_value, [35:18] cosine_value, [39:36] zero

  longint     whole_deg_sine [0:90];
  longint     centi_sine     [0:50];
  longint     centi_cosine   [0:50];
  trig_pair_t pending_pairs  [$];
  int         error_count  = 0;
  int         holdoff_len  = 0;
  int         burst_left   = 0;

  sine_cosine_from_centidegrees_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wide;
    wide = {64'd0, a} * {64'd0, b};
    return wide[125:62];
  endfunction

  // Taylor series, 14 terms past the first, for 0..pi/2 in Q62
  function automatic logic [63:0] taylor_q62(input logic [63:0] x, input bit odd_series);
    logic [63:0] x_sq;
    logic [63:0] term;
    logic [63:0] total;
    logic [63:0] n;
    x_sq  = q62_product(x, x);
    term  = odd_series ? x : ONE_Q62;
    total = term;
    n     = odd_series ? 64'd1 : 64'd0;
    for (int k = 0; k < 14; k++) begin
      term = q62_product(term, x_sq) / ((n + 64'd1) * (n + 64'd2));
      n    = n + 64'd2;
      if (k % 2 == 1) total = total + term;
      else total = total - term;
    end
    return total;
  endfunction

  function automatic longint round_to_rom(input logic [63:0] v);
    logic [63:0] t;
    t = v + (64'd1 << (61 - FRAC));
    return longint'(t >> (62 - FRAC));
  endfunction

  task automatic build_trig_tables();
    logic [63:0] deg_step;
    logic [63:0] centi_step;
    deg_step   = PI_Q62 / 180;
    centi_step = PI_Q62 / 18000;
    for (int i = 0; i <= 90; i++)
      whole_deg_sine[i] = round_to_rom(taylor_q62(deg_step * 64'(i), 1'b1));
    for (int i = 0; i <= 50; i++) begin
      centi_sine[i]   = round_to_rom(taylor_q62(centi_step * 64'(i), 1'b1));
      centi_cosine[i] = round_to_rom(taylor_q62(centi_step * 64'(i), 1'b0));
    end
  endtask

  // sine of deg + frac/100 degrees, folded onto the first quadrant
  function automatic longint fold_sine(input int unsigned deg, input int unsigned frac);
    bit     flip;
    bit     reflect;
    longint acc;
    longint half;
    longint mag;
    flip    = 1'b0;
    reflect = 1'b0;
    deg     = deg % 360;
    if (frac > 99) frac = 99;
    if (deg >= 180) begin
      flip = 1'b1;
      deg  = deg - 180;
    end
    if (deg >= 90) begin
      deg = 180 - deg;
      if (frac > 0) begin
        deg  = deg - 1;
        frac = 100 - frac;
      end
    end
    // hundredths above 50 borrow from the next whole degree
    if (frac > 50) begin
      reflect = 1'b1;
      frac    = 100 - frac;
      deg     = deg + 1;
    end
    if (deg > 90) deg = 90;
    if (frac > 50) frac = 50;
    acc = centi_cosine[frac] * whole_deg_sine[deg];
    if (reflect) acc = acc - centi_sine[frac] * whole_deg_sine[90 - deg];
    else acc = acc + centi_sine[frac] * whole_deg_sine[90 - deg];
    half = longint'(1) << (FRAC - 1);
    if (acc >= 0) mag = (acc + half) >>> FRAC;
    else mag = -((-acc + half) >>> FRAC);
    return flip ? -mag : mag;
  endfunction

  function automatic trig_pair_t predict_sine_cosine(input logic [15:0] angle);
    trig_pair_t  pair;
    int unsigned deg;
    int unsigned frac;
    int unsigned deg_mod;
    longint      s;
    longint      c;
    deg     = angle / 100;
    frac    = angle % 100;
    deg_mod = deg % 360;
    s = fold_sine(deg, frac);
    // cosine runs the sine path on the reflected argument
    if (frac == 0) c = fold_sine(450 - deg_mod, 0);
    else c = fold_sine(449 - deg_mod, 100 - frac);
    pair.angle    = angle;
    pair.sine_q   = 18'(s);
    pair.cosine_q = 18'(c);
    return pair;
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin : result_check
    trig_pair_t         want;
    logic signed [17:0] got_sine;
    logic signed [17:0] got_cosine;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_sine   = m_axis_tdata[17:0];
      got_cosine = m_axis_tdata[35:18];
      if (pending_pairs.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual tdata %h",
                 $realtime, m_axis_tdata);
      end else begin
        want = pending_pairs.pop_front();
        if (got_sine !== want.sine_q) begin
          error_count++;
          $display("%0t: angle %0d sine, expected %0d, actual %0d",
                   $realtime, want.angle, want.sine_q, got_sine);
        end
        if (got_cosine !== want.cosine_q) begin
          error_count++;
          $display("%0t: angle %0d cosine, expected %0d, actual %0d",
                   $realtime, want.angle, want.cosine_q, got_cosine);
        end
        if (m_axis_tdata[39:36] !== 4'd0) begin
          error_count++;
          $display("%0t: angle %0d pad bits, expected 0, actual %h",
                   $realtime, want.angle, m_axis_tdata[39:36]);
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // ready pattern changes per segment; a hold-off request overrides it
  initial begin : result_sink
    sink_mode_e mode;
    int         seg_left;
    int         phase;
    mode     = SINK_OPEN;
    seg_left = 0;
    phase    = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (holdoff_len > 0) begin
        m_axis_tready <= 1'b0;
        holdoff_len--;
      end else begin
        if (seg_left == 0) begin
          mode     = sink_mode_e'($urandom_range(0, 3));
          seg_left = $urandom_range(20, 80);
        end
        seg_left--;
        phase++;
        case (mode)
          SINK_OPEN:     m_axis_tready <= 1'b1;
          SINK_LIGHT:    m_axis_tready <= ($urandom_range(0, 3) != 0);
          SINK_HEAVY:    m_axis_tready <= ($urandom_range(0, 3) == 0);
          SINK_PERIODIC: m_axis_tready <= ((phase % 7) < 4);
          default:       m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic send_angle(input logic [15:0] angle);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= angle;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_pairs.push_back(predict_sine_cosine(angle));
  endtask

  task automatic idle_sender(input int cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 16'($urandom);
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // sends in bursts; a quarter of the bursts follow the last with no gap
  task automatic send_paced(input logic [15:0] angle);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) idle_sender(gap);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    send_angle(angle);
  endtask

  // ---------------------------------------------------------------- tests

  // zero, all ones, quarter turns, wrap past 360, fraction 50/51 boundary
  task automatic test_corner_angles();
    logic [15:0] corner_angles [25] = '{
      16'd0,     16'd1,     16'd50,    16'd51,    16'd99,
      16'd100,   16'd4500,  16'd4550,  16'd4551,  16'd8999,
      16'd9000,  16'd9001,  16'd13549, 16'd18000, 16'd18050,
      16'd26950, 16'd27000, 16'd27099, 16'd35999, 16'd36000,
      16'd36001, 16'd45000, 16'd32768, 16'd65500, 16'd65535};
    foreach (corner_angles[i]) send_paced(corner_angles[i]);
  endtask

  task automatic test_fraction_edges();
    int unsigned edge_fracs [6] = '{0, 1, 49, 50, 51, 99};
    int unsigned whole;
    repeat (100) begin
      whole = $urandom_range(0, 654);
      send_paced(16'(whole * 100 + edge_fracs[$urandom_range(0, 5)]));
    end
  endtask

  task automatic test_one_turn();
    repeat (150) send_paced(16'($urandom_range(0, 35999)));
  endtask

  task automatic test_full_range();
    repeat (200) send_paced(16'($urandom_range(0, 65535)));
  endtask

  // receiver holds off long enough for the pipeline to fill and stall input
  task automatic test_output_holdoff();
    holdoff_len = 80;
    repeat (40) send_angle(16'($urandom_range(0, 65535)));
  endtask

  task automatic drain_and_report();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (LATENCY * 3) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  endtask

  initial begin : run_tests
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 16'd0;
    m_axis_tready = 1'b0;
    build_trig_tables();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_corner_angles();
    test_fraction_edges();
    test_output_holdoff();
    test_one_turn();
    test_full_range();
    drain_and_report();
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_CAP) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

endmodule
